// ===== rtl/core/cfad_pkg.sv =====
// Shared types and constants for the CAN frame anomaly detector core.
package cfad_pkg;

	localparam int WindowDepthDef = 16;
	localparam int BaselineEntriesDef = 128;
	localparam int NumRangesDef = 6;

	localparam logic [28:0] TempIdLow = 29'h300;
	localparam logic [28:0] TempIdHigh = 29'h399;
	localparam logic [7:0] TempLimitRst = 8'd120;
	localparam logic [4:0] FloodThreshRst = 5'd11;

	typedef enum logic [2:0] {
		VERDICT_NORMAL  = 3'd0,
		VERDICT_ANOMALY = 3'd1,
		VERDICT_FLOOD   = 3'd2,
		VERDICT_LEARNED = 3'd3,
		VERDICT_FULL    = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SCAN,
		ST_OUT
	} state_t;

	// register indexes
	localparam logic [2:0] RegTempLimit = 3'd6;
	localparam logic [2:0] RegFloodThresh = 3'd7;

	// search request handed down the table chain
	typedef struct packed {
		logic        vld;
		logic [28:0] id;
	} probe_t;

endpackage

// ===== rtl/core/cfad_tbl_cell.sv =====
// One baseline table cell: holds an identifier and length, passes a probe on.
module cfad_tbl_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfad_pkg::probe_t     probe_in,
	input  logic                 used,
	input  logic                 wr_en,
	input  logic [28:0]          wr_id,
	input  logic [3:0]           wr_len,
	output cfad_pkg::probe_t     probe_out,
	output logic                 hit,
	output logic [3:0]           len
);
	logic [28:0] id_q;
	logic [3:0]  len_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q <= wr_id;
			len_q <= wr_len;
		end
	end

	// pass the probe to the neighbor through a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_out <= '0;
		end else begin
			probe_out <= probe_in;
		end
	end

	assign hit = probe_in.vld && used && (id_q == probe_in.id);
	assign len = len_q;
endmodule

// ===== rtl/core/can_frame_anomaly_detector_core.sv =====
// Top level of the CAN frame anomaly detector core.
// channel | dir | handshake        | payload
// s_axis  | in  | tvalid/tready    | tdata: mode, frame_id, frame_len, first_byte
// m_axis  | out | tvalid/tready    | tdata: verdict, entries_used
// apb     | in  | psel/penable     | range_0..5, temp_limit, flood_threshold
// One frame at a time. A probe walks the chain of BASELINE_ENTRIES table
// cells, one cell a cycle; a passing detect frame that leaves the window full
// then sweeps the 256 byte counters through a registered read.
// Reset clears control, fill counts and counters (count array by a valid bit
// per entry). A held result blocks the input. A held result does not block
// configuration.
module can_frame_anomaly_detector_core #(
	parameter int WINDOW_DEPTH = cfad_pkg::WindowDepthDef,
	parameter int BASELINE_ENTRIES = cfad_pkg::BaselineEntriesDef,
	parameter int NUM_RANGES = cfad_pkg::NumRangesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // mode[0], frame_id[29:1], frame_len[33:30], first_byte[41:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata, // verdict[2:0], entries_used[10:3]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int EW = $clog2(BASELINE_ENTRIES + 1);
	localparam int AW = (BASELINE_ENTRIES > 1) ? $clog2(BASELINE_ENTRIES) : 1;
	localparam int PW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	// configuration
	logic [63:0] range_q [6];
	logic [7:0]  temp_limit_q;
	logic [4:0]  flood_thr_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) range_q[i] <= '0;
			temp_limit_q <= cfad_pkg::TempLimitRst;
			flood_thr_q <= cfad_pkg::FloodThreshRst;
		end else if (cfg_wr) begin
			if (cfg_idx == cfad_pkg::RegTempLimit) temp_limit_q <= pwdata[7:0];
			else if (cfg_idx == cfad_pkg::RegFloodThresh) flood_thr_q <= pwdata[4:0];
			else range_q[cfg_idx] <= pwdata;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			cfad_pkg::RegTempLimit: prdata = {56'd0, temp_limit_q};
			cfad_pkg::RegFloodThresh: prdata = {59'd0, flood_thr_q};
			default: prdata = range_q[cfg_idx];
		endcase
	end

	// input item
	cfad_pkg::state_t state_q, state_d;
	logic        mode_q;
	logic [28:0] id_q;
	logic [3:0]  len_q;
	logic [7:0]  fb_q;
	logic [EW-1:0] used_q;
	logic [AW:0] walk_q;
	logic        found_q;
	logic [3:0]  flen_q;
	logic [AW-1:0] fslot_q;
	cfad_pkg::verdict_t verdict_q;
	logic        in_xfer;

	assign s_axis_tready = (state_q == cfad_pkg::ST_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// table chain; the probe enters cell 0 in the first search cycle
	cfad_pkg::probe_t probe [BASELINE_ENTRIES+1];
	logic [BASELINE_ENTRIES-1:0] hit;
	logic [3:0] clen [BASELINE_ENTRIES];
	logic tbl_wr;
	logic [AW-1:0] tbl_addr;

	assign probe[0].vld = (state_q == cfad_pkg::ST_SEARCH) && (walk_q == '0);
	assign probe[0].id = id_q;

	for (genvar g = 0; g < BASELINE_ENTRIES; g++) begin : g_cell
		cfad_tbl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe_in (probe[g]),
			.used     (EW'(g) < used_q),
			.wr_en    (tbl_wr && (tbl_addr == AW'(g))),
			.wr_id    (id_q),
			.wr_len   (len_q),
			.probe_out(probe[g+1]),
			.hit      (hit[g]),
			.len      (clen[g])
		);
	end

	// one cell hits at a time as the probe walks; latch it
	logic any_hit;
	logic [AW-1:0] hit_slot;
	always_comb begin
		any_hit = 1'b0;
		hit_slot = '0;
		for (int i = 0; i < BASELINE_ENTRIES; i++) begin
			if (hit[i] && !any_hit) begin
				any_hit = 1'b1;
				hit_slot = AW'(i);
			end
		end
	end

	// range check and temperature check
	logic id_ok, temp_bad;
	always_comb begin
		id_ok = 1'b0;
		for (int r = 0; r < NUM_RANGES; r++) begin
			if ({3'd0, id_q} >= range_q[r][31:0] && {3'd0, id_q} <= range_q[r][63:32])
				id_ok = 1'b1;
		end
		temp_bad = (id_q >= cfad_pkg::TempIdLow) && (id_q <= cfad_pkg::TempIdHigh) &&
			(fb_q > temp_limit_q);
	end

	// window ring and counters
	logic [7:0] ring_q [WINDOW_DEPTH];
	logic [PW-1:0] wpos_q;
	logic [FW-1:0] wfill_q;
	logic [CW-1:0] cnt_q [256];
	logic [255:0] cvld_q;
	logic [8:0] scan_q;
	logic flood_q;
	logic push;
	logic [7:0] old_b, new_b;
	logic [7:0] rda_addr;
	logic [CW-1:0] rda_q, rdb_q;
	logic vlda_q, vldb_q;
	logic [CW-1:0] cnt_a, cnt_b;
	logic scan_hit;

	assign new_b = id_q[7:0];
	assign old_b = ring_q[wpos_q];
	// port a: evicted byte while deciding, sweep address while scanning
	assign rda_addr = (state_q == cfad_pkg::ST_SCAN) ? scan_q[7:0] : old_b;
	assign cnt_a = vlda_q ? rda_q : '0;
	assign cnt_b = vldb_q ? rdb_q : '0;
	// read data is registered and arrives the cycle after its sweep address
	assign scan_hit = (scan_q != 9'd0) &&
		({{(32-CW){1'b0}}, cnt_a} > {27'd0, flood_thr_q});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfad_pkg::ST_IDLE: if (in_xfer) state_d = cfad_pkg::ST_SEARCH;
			cfad_pkg::ST_SEARCH:
				if (walk_q == (AW+1)'(BASELINE_ENTRIES - 1)) state_d = cfad_pkg::ST_DECIDE;
			cfad_pkg::ST_DECIDE:
				state_d = push && (FW'(wfill_q) >= FW'(WINDOW_DEPTH - 1)) ?
					cfad_pkg::ST_SCAN : cfad_pkg::ST_OUT;
			cfad_pkg::ST_SCAN: if (scan_q == 9'd256) state_d = cfad_pkg::ST_OUT;
			cfad_pkg::ST_OUT: if (m_axis_tready) state_d = cfad_pkg::ST_IDLE;
			default: state_d = cfad_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		push = 1'b0;
		tbl_wr = 1'b0;
		tbl_addr = fslot_q;
		if (state_q == cfad_pkg::ST_DECIDE) begin
			if (mode_q) begin
				if (found_q) tbl_wr = 1'b1;
				else if (used_q < EW'(BASELINE_ENTRIES)) begin
					tbl_wr = 1'b1;
					tbl_addr = AW'(used_q);
				end
			end else begin
				push = id_ok && !(found_q && flen_q != len_q) && !temp_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfad_pkg::ST_IDLE;
			used_q <= '0;
			walk_q <= '0;
			found_q <= 1'b0;
			wpos_q <= '0;
			wfill_q <= '0;
			cvld_q <= '0;
			scan_q <= '0;
			flood_q <= 1'b0;
			verdict_q <= cfad_pkg::VERDICT_NORMAL;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				walk_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == cfad_pkg::ST_SEARCH) begin
				walk_q <= walk_q + 1'b1;
				if (any_hit) found_q <= 1'b1;
			end
			if (state_q == cfad_pkg::ST_DECIDE) begin
				scan_q <= '0;
				flood_q <= 1'b0;
				if (mode_q) begin
					if (found_q) verdict_q <= cfad_pkg::VERDICT_LEARNED;
					else if (used_q < EW'(BASELINE_ENTRIES)) begin
						verdict_q <= cfad_pkg::VERDICT_LEARNED;
						used_q <= used_q + 1'b1;
					end else verdict_q <= cfad_pkg::VERDICT_FULL;
				end else if (!push) begin
					verdict_q <= cfad_pkg::VERDICT_ANOMALY;
				end else begin
					verdict_q <= cfad_pkg::VERDICT_NORMAL;
					wpos_q <= (wpos_q == PW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
					if (wfill_q < FW'(WINDOW_DEPTH)) wfill_q <= wfill_q + 1'b1;
					cvld_q[new_b] <= 1'b1;
					if (wfill_q >= FW'(WINDOW_DEPTH)) cvld_q[old_b] <= 1'b1;
				end
			end
			if (state_q == cfad_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
				if (scan_hit) begin
					flood_q <= 1'b1;
				end
				if (scan_q == 9'd256 && (flood_q || scan_hit))
					verdict_q <= cfad_pkg::VERDICT_FLOOD;
			end
		end
	end

	// payload registers and ring
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= s_axis_tdata[0];
			id_q <= s_axis_tdata[29:1];
			len_q <= s_axis_tdata[33:30];
			fb_q <= s_axis_tdata[41:34];
		end
		if (state_q == cfad_pkg::ST_SEARCH && any_hit && !found_q) begin
			fslot_q <= hit_slot;
			flen_q <= clen[hit_slot];
		end
		vlda_q <= cvld_q[rda_addr];
		vldb_q <= cvld_q[new_b];
		if (push) begin
			ring_q[wpos_q] <= new_b;
		end
	end

	// counter store: registered reads, addresses settle during the search
	always_ff @(posedge clk) begin
		rda_q <= cnt_q[rda_addr];
		rdb_q <= cnt_q[new_b];
		if (push) begin
			if (wfill_q >= FW'(WINDOW_DEPTH) && old_b != new_b) begin
				cnt_q[old_b] <= (cnt_a != '0) ? cnt_a - 1'b1 : '0;
				cnt_q[new_b] <= cnt_b + 1'b1;
			end else if (wfill_q < FW'(WINDOW_DEPTH)) begin
				cnt_q[new_b] <= cnt_b + 1'b1;
			end
		end
	end

	assign m_axis_tvalid = (state_q == cfad_pkg::ST_OUT);
	assign m_axis_tdata = {5'd0, 8'(used_q), verdict_q};

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= EW'(BASELINE_ENTRIES)) else $error("table count overflow");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wfill_q <= FW'(WINDOW_DEPTH)) else $error("window fill overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result held");
`endif
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the CAN frame anomaly detector core.
`timescale 1ns / 1ps

// Tracks detector state and holds the verdicts still owed by the core
class frame_verdict_board;
	localparam int Depth = cfad_pkg::WindowDepthDef;
	localparam int Slots = cfad_pkg::BaselineEntriesDef;

	logic [63:0] rng [cfad_pkg::NumRangesDef];
	logic [7:0]  temp_lim;
	logic [4:0]  flood_lim;
	logic [28:0] tbl_id [$];
	logic [3:0]  tbl_len [$];
	logic [7:0]  ring [Depth];
	int          ring_pos;
	int          ring_fill;
	int          byte_cnt [256];
	cfad_pkg::verdict_t due_verdict [$];
	int          due_used [$];
	int          errors;
	int          seen [5];

	function new();
		for (int r = 0; r < cfad_pkg::NumRangesDef; r++) rng[r] = '0;
		temp_lim = cfad_pkg::TempLimitRst;
		flood_lim = cfad_pkg::FloodThreshRst;
		ring_pos = 0;
		ring_fill = 0;
		errors = 0;
		for (int i = 0; i < 256; i++) byte_cnt[i] = 0;
		for (int i = 0; i < 5; i++) seen[i] = 0;
	endfunction

	function void set_reg(int idx, logic [63:0] v);
		if (idx < cfad_pkg::NumRangesDef) rng[idx] = v;
		else if (idx == cfad_pkg::RegTempLimit) temp_lim = v[7:0];
		else if (idx == cfad_pkg::RegFloodThresh) flood_lim = v[4:0];
	endfunction

	function int slot_of(logic [28:0] id);
		foreach (tbl_id[i]) if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function int pending();
		return due_verdict.size();
	endfunction

	// low byte enters the window; returns 1 on flood
	function bit push_byte(logic [7:0] b);
		bit flood;
		flood = 0;
		if (ring_fill >= Depth && byte_cnt[ring[ring_pos]] > 0) byte_cnt[ring[ring_pos]]--;
		ring[ring_pos] = b;
		byte_cnt[b]++;
		ring_pos = (ring_pos + 1) % Depth;
		if (ring_fill < Depth) ring_fill++;
		if (ring_fill >= Depth)
			for (int i = 0; i < 256; i++) if (byte_cnt[i] > flood_lim) flood = 1;
		return flood;
	endfunction

	// accepted frame: work out its verdict
	function void note_frame(logic [47:0] d);
		logic        learn;
		logic [28:0] id;
		logic [3:0]  len;
		logic [7:0]  fb;
		int          slot;
		bit          ok;
		cfad_pkg::verdict_t v;
		learn = d[0];
		id = d[29:1];
		len = d[33:30];
		fb = d[41:34];
		slot = slot_of(id);
		if (learn) begin
			if (slot >= 0) begin
				tbl_len[slot] = len;
				v = cfad_pkg::VERDICT_LEARNED;
			end else if (tbl_id.size() < Slots) begin
				tbl_id.push_back(id);
				tbl_len.push_back(len);
				v = cfad_pkg::VERDICT_LEARNED;
			end else begin
				v = cfad_pkg::VERDICT_FULL;
			end
		end else begin
			ok = 0;
			for (int r = 0; r < cfad_pkg::NumRangesDef; r++)
				if ({3'b0, id} >= rng[r][31:0] && {3'b0, id} <= rng[r][63:32]) ok = 1;
			if (!ok) v = cfad_pkg::VERDICT_ANOMALY;
			else if (slot >= 0 && tbl_len[slot] != len) v = cfad_pkg::VERDICT_ANOMALY;
			else if (id >= cfad_pkg::TempIdLow && id <= cfad_pkg::TempIdHigh &&
				fb > temp_lim) v = cfad_pkg::VERDICT_ANOMALY;
			else v = push_byte(id[7:0]) ? cfad_pkg::VERDICT_FLOOD : cfad_pkg::VERDICT_NORMAL;
		end
		due_verdict.push_back(v);
		due_used.push_back(tbl_id.size());
	endfunction

	// result transfer: compare with the oldest expectation
	function void check_result(logic [15:0] d);
		cfad_pkg::verdict_t ev;
		int       eu;
		if (due_verdict.size() == 0) begin
			$display("%0t: unexpected result verdict=%0d used=%0d", $time, d[2:0], d[10:3]);
			errors++;
			return;
		end
		ev = due_verdict.pop_front();
		eu = due_used.pop_front();
		if (d[2:0] !== ev) begin
			$display("%0t: verdict expected %0d actual %0d", $time, ev, d[2:0]);
			errors++;
		end
		if (d[10:3] !== eu[7:0]) begin
			$display("%0t: entries_used expected %0d actual %0d", $time, eu[7:0], d[10:3]);
			errors++;
		end
		if (d[2:0] < 5) seen[d[2:0]]++;
		if (d[15:11] !== 0) begin
			$display("%0t: pad bits expected 0 actual %h", $time, d[15:11]);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam longint CycleLimit = 3000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0; // mode, frame_id, frame_len, first_byte, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata; // verdict, entries_used, zero pad
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	frame_verdict_board board;
	longint      cycles = 0;
	int          hold_off = 0;
	bit          steady = 0;
	int          frames_sent = 0;
	logic [28:0] id_pool [$];

	can_frame_anomaly_detector_core dut (.*);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// monitor both streams
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) board.note_frame(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// result side: random stalls plus the requested long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready = 0;
				hold_off--;
			end else begin
				stall = pick_gap();
				m_axis_tready = (stall == 0);
				repeat (stall > 0 ? stall - 1 : 0) @(negedge clk);
			end
		end
	end

	task automatic write_reg(int idx, logic [63:0] v);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = 6'(idx * 8);
		pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		board.set_reg(idx, v);
	endtask

	task automatic send_frame(logic learn, logic [28:0] id, logic [3:0] len, logic [7:0] fb);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {6'b0, fb, len, id, learn};
		s_axis_tvalid = 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		frames_sent++;
	endtask

	// drain all results before touching registers
	task automatic settle();
		if (s_axis_tvalid) s_axis_tvalid = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_range();
		logic [31:0] lo;
		int r;
		r = $urandom_range(99);
		lo = 32'(id_pool[$urandom_range(id_pool.size() - 1)]);
		if (r < 25) return {32'hFFFF_FFFF, 32'h0};
		if (r < 60) return {lo + $urandom_range(4000), lo - $urandom_range(50)};
		if (r < 75) return {lo - 32'd1, lo};
		return {$urandom(), $urandom()};
	endfunction

	// one random frame; fill_table favors fresh identifiers in learn mode
	task automatic random_frame(bit fill_table, bit hot_byte);
		logic        learn;
		logic [28:0] id;
		logic [3:0]  len;
		logic [7:0]  fb;
		int          slot;
		learn = fill_table ? ($urandom_range(9) != 0) : ($urandom_range(9) < 3);
		if (fill_table || $urandom_range(9) == 0) id = 29'($urandom());
		else id = id_pool[$urandom_range(id_pool.size() - 1)];
		if (hot_byte && $urandom_range(3) != 0) id[7:0] = 8'h5A;
		slot = board.slot_of(id);
		len = (slot >= 0 && $urandom_range(9) < 7) ? board.tbl_len[slot] :
			4'($urandom_range(15));
		fb = $urandom_range(1) ? 8'($urandom()) :
			8'(board.temp_lim + $urandom_range(2) - 1);
		send_frame(learn, id, len, fb);
	endtask

	initial begin
		logic [4:0] th_set [4] = '{5'd0, 5'd16, 5'd31, 5'd3};
		logic [7:0] tl_set [4] = '{8'd0, 8'd255, 8'd120, 8'd60};
		board = new();
		id_pool = '{29'h0, 29'h1FFF_FFFF, 29'h300, 29'h355, 29'h399, 29'h39A, 29'h2FF, 29'h7FF};
		repeat (24) id_pool.push_back({$urandom_range(3) == 0 ? 18'($urandom()) : 18'h0,
			3'($urandom()), 8'($urandom_range(3) * 8'h55)});
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: default ranges admit only identifier 0
		send_frame(1'b0, 29'h0, 4'd0, 8'h00);
		send_frame(1'b0, 29'h1FFF_FFFF, 4'd15, 8'hFF);
		send_frame(1'b1, 29'h0, 4'd8, 8'h00);
		send_frame(1'b0, 29'h0, 4'd8, 8'hFF);
		send_frame(1'b0, 29'h0, 4'd3, 8'h00);
		send_frame(1'b1, 29'h0, 4'd15, 8'h00);
		send_frame(1'b0, 29'h0, 4'd15, 8'h00);
		send_frame(1'b1, 29'h1FFF_FFFF, 4'd0, 8'hFF);
		send_frame(1'b1, 29'h355, 4'd2, 8'h00);
		settle();

		// temperature window, an empty range (start above end), top identifiers
		write_reg(0, {32'h399, 32'h300});
		write_reg(1, {32'h1FFF_FFFF, 32'h1FFF_FF00});
		write_reg(2, {32'h0, 32'h5});
		write_reg(3, {32'h7FF, 32'h0});
		write_reg(4, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		write_reg(5, {32'h0, 32'hFFFF_FFFF});
		write_reg(int'(cfad_pkg::RegTempLimit), 64'd120);
		write_reg(int'(cfad_pkg::RegFloodThresh), 64'd0);
		send_frame(1'b0, 29'h300, 4'd1, 8'd120);
		send_frame(1'b0, 29'h300, 4'd1, 8'd121);
		send_frame(1'b0, 29'h399, 4'd7, 8'hFF);
		send_frame(1'b0, 29'h39A, 4'd7, 8'hFF);
		send_frame(1'b0, 29'h355, 4'd2, 8'h10);
		send_frame(1'b0, 29'h355, 4'd9, 8'h10);
		send_frame(1'b0, 29'h1FFF_FFFF, 4'd0, 8'h00);
		send_frame(1'b0, 29'h2FF, 4'd0, 8'h00);
		repeat (14) send_frame(1'b0, 29'h7FF, 4'd4, 8'h00);
		settle();

		// random phases over a spread of settings
		for (int ph = 0; ph < 9; ph++) begin
			for (int r = 0; r < cfad_pkg::NumRangesDef; r++) write_reg(r, pick_range());
			write_reg(int'(cfad_pkg::RegTempLimit),
				ph < 4 ? 64'(tl_set[ph]) : 64'($urandom_range(255)));
			write_reg(int'(cfad_pkg::RegFloodThresh),
				ph < 4 ? 64'(th_set[ph]) : 64'($urandom_range(16, 8)));
			steady = (ph == 5);
			if (ph == 2) hold_off = 400;
			repeat (ph == 6 ? 160 : 120) random_frame(ph == 6, ph == 3 || ph == 7);
			settle();
		end
		steady = 0;
		repeat (400) @(posedge clk);

		$display("%0d frames sent, %0d table entries, verdicts normal/anomaly/flood/learned/full:",
			frames_sent, board.tbl_id.size());
		$display("  %0d / %0d / %0d / %0d / %0d", board.seen[0], board.seen[1],
			board.seen[2], board.seen[3], board.seen[4]);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== can_frame_anomaly_detector_core.f =====
rtl/core/cfad_pkg.sv
rtl/core/cfad_tbl_cell.sv
rtl/core/can_frame_anomaly_detector_core.sv
verif/tb.sv
